[src/tce_pkg.sv]
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types, constants and arithmetic helpers for the tricorn
// escape-time block.
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

  // Point format: signed Q5.FRAC_BITS.
  localparam int FRAC_BITS  = 27;
  localparam int COORD_BITS = 12;
  localparam int WBITS      = FRAC_BITS + 5;
  localparam int CNT_W      = 16;

  // Configuration register widths.
  localparam int OFF_W = 32;            // Q16.16
  localparam int INV_W = 40;            // Q0.40
  localparam int CFG_W = 40;            // widest register
  localparam int CFG_IDX_W = 2;

  localparam logic [INV_W-1:0] INV_SCALE_RST = 40'd5497558139;
  localparam logic [CNT_W-1:0] MAX_ITER_RST  = 16'd64;

  // Pixel-to-point mapping: |pixel<<16 - offset| * inv_scale >> MAP_SH.
  localparam int PIX_SH   = 16;
  localparam int D_W      = OFF_W + 2;   // signed difference
  localparam int DMAG_W   = OFF_W;       // magnitude stays below 2^32
  localparam int INV_LO_W = INV_W / 2;
  localparam int INV_HI_W = INV_W - INV_LO_W;
  localparam int MPROD_W  = DMAG_W + INV_LO_W;
  localparam int ACC_W    = DMAG_W + INV_W;
  localparam int MAP_SH   = 56 - FRAC_BITS;
  localparam int Q_W      = ACC_W - MAP_SH;

  // Iteration: only magnitudes below 2.0 are ever squared for real.
  localparam int MAG_W  = FRAC_BITS + 1;
  localparam int PROD_W = 2 * MAG_W;
  localparam int SQ_W   = PROD_W - FRAC_BITS;       // square, Q.FRAC, < 4.0
  localparam int TW_W   = PROD_W - FRAC_BITS + 1;   // 2*zr*zi
  localparam int ZW     = WBITS + 3;                // unsaturated sums

  localparam logic signed [WBITS-1:0] VMAX = {1'b0, {(WBITS-1){1'b1}}};
  localparam logic signed [WBITS-1:0] VMIN = {1'b1, {(WBITS-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X,
    CFG_OFFSET_Y,
    CFG_INV_SCALE,
    CFG_MAX_ITER
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_MUL,
    ST_UPD
  } tce_state_t;

  // Steps of the coordinate mapping sequence.
  typedef enum logic [2:0] {
    MS_X_LO,
    MS_X_HI,
    MS_X_ADD,
    MS_Y_HI,
    MS_Y_ADD,
    MS_Y_WR
  } map_step_t;

  typedef struct packed {
    logic load;        // capture pixel, clear z and count
    logic mul_en;      // mapping multiplier register enable
    logic mul_sel_y;   // 0: x difference, 1: y difference
    logic mul_sel_hi;  // 0: low half of inv_scale, 1: high half
    logic acc_load;
    logic acc_add;
    logic wr_cr;
    logic wr_ci;
    logic sq_en;       // register the three products of z
    logic z_upd;       // take the next z, count up
    logic out_wr;      // load the result register
  } tce_cmd_t;

  typedef struct packed {
    logic esc;         // current z has escaped
    logic at_max;      // count equals max_iter
  } tce_sts_t;

  // Clamp a wide signed sum to the point word.
  function automatic logic signed [WBITS-1:0] sat_word(input logic signed [ZW-1:0] v);
    logic ovf;
    ovf = (v[ZW-1:WBITS-1] != {(ZW-WBITS+1){1'b0}}) &&
          (v[ZW-1:WBITS-1] != {(ZW-WBITS+1){1'b1}});
    if (ovf) begin
      return v[ZW-1] ? VMIN : VMAX;
    end
    return v[WBITS-1:0];
  endfunction

  // Truncated product magnitude plus sign, clamped to the point word.
  function automatic logic signed [WBITS-1:0] map_sat(input logic [Q_W-1:0] q,
                                                      input logic neg);
    logic big;
    big = |q[Q_W-1:WBITS-1];
    if (big) begin
      return neg ? VMIN : VMAX;
    end
    return neg ? -q[WBITS-1:0] : q[WBITS-1:0];
  endfunction

endpackage

`default_nettype wire

[src/tce_if.sv]
// ----------------------------------------------------------------------------
// tce_if
// Valid/ready stream interfaces for the pixel and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tce_in_if;
  import tce_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface tce_out_if;
  import tce_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [CNT_W-1:0]      iteration_count;
  logic                  inside_res;

  modport source (output valid, output out_x, output out_y, output iteration_count,
                  output inside_res, input ready);
  modport sink   (input valid, input out_x, input out_y, input iteration_count,
                  input inside_res, output ready);
endinterface

`default_nettype wire

[src/tricorn_escape_time.sv]
// ----------------------------------------------------------------------------
// tricorn_escape_time
// Escape-time engine for the power-2 tricorn set: pixel in, iteration
// count and inside flag out.
// ----------------------------------------------------------------------------
// Each pixel is mapped to c = (pixel<<16 - offset) * inv_scale in signed
// Q5.27, then z = conj(z)^2 + c' is iterated from zero (zr' = zr^2 - zi^2 - cr,
// zi' = ci - 2 zr zi) until |z|^2 >= 4 or max_iter steps, all saturating.
// One pixel is in flight at a time. Each pixel runs a capture step, the
// mapping steps (32x20 multiplier, two partial products per coordinate),
// then per escape iteration a square step (z into registers) and an update
// and test step, plus one final test pass, which holds until the output
// register is free.
// The result sits in an output register, so a new pixel beat is taken while
// the previous result still waits. Registers are written through cfg_we /
// cfg_index / cfg_data and should only change while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tricorn_escape_time
  import tce_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  tce_in_if.sink               in_chan,
  tce_out_if.source            out_chan,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_W-1:0]      cfg_data
);

  // configuration registers
  logic [OFF_W-1:0] offset_x_r;
  logic [OFF_W-1:0] offset_y_r;
  logic [INV_W-1:0] inv_scale_r;
  logic [CNT_W-1:0] max_iter_r;

  tce_cmd_t cmd;
  tce_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r  <= '0;
      offset_y_r  <= '0;
      inv_scale_r <= INV_SCALE_RST;
      max_iter_r  <= MAX_ITER_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OFFSET_X:  offset_x_r  <= cfg_data[OFF_W-1:0];
        CFG_OFFSET_Y:  offset_y_r  <= cfg_data[OFF_W-1:0];
        CFG_INV_SCALE: inv_scale_r <= cfg_data[INV_W-1:0];
        CFG_MAX_ITER:  max_iter_r  <= cfg_data[CNT_W-1:0];
      endcase
    end
  end

  // sequencer
  tce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic
  tce_dp u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .pixel_x         (in_chan.pixel_x),
    .pixel_y         (in_chan.pixel_y),
    .offset_x        (offset_x_r),
    .offset_y        (offset_y_r),
    .inv_scale       (inv_scale_r),
    .max_iter        (max_iter_r),
    .out_x           (out_chan.out_x),
    .out_y           (out_chan.out_y),
    .iteration_count (out_chan.iteration_count),
    .inside_res      (out_chan.inside_res)
  );

`ifndef NO_ASSERTIONS
  // a pending result agrees with the limit it was computed against
  a_inside_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.inside_res == (out_chan.iteration_count == max_iter_r)))
    else $error("inside flag disagrees with count");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.iteration_count <= max_iter_r))
    else $error("count beyond limit");

  // one pixel at a time: a taken beat closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input open right after a beat");
`endif

endmodule

`default_nettype wire

[src/tce_ctrl.sv]
// ----------------------------------------------------------------------------
// tce_ctrl
// Sequencer: pixel capture, coordinate mapping steps, then the
// multiply / update loop until escape or limit.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_ctrl
  import tce_pkg::*;
(
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  wire      out_ready,
  input  tce_sts_t sts,
  output tce_cmd_t cmd
);

  tce_state_t state_r, state_nxt;
  map_step_t  step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       finish;
  logic       out_free;

  assign finish   = sts.esc || sts.at_max;
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MAP;
      ST_MAP:  if (step_r == MS_Y_WR) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_UPD;
      ST_UPD: begin
        if (!finish) begin
          state_nxt = ST_MUL;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MAP: begin
        unique case (step_r)
          MS_X_LO: begin
            cmd.mul_en = 1'b1;
          end
          MS_X_HI: begin
            cmd.acc_load   = 1'b1;
            cmd.mul_en     = 1'b1;
            cmd.mul_sel_hi = 1'b1;
          end
          MS_X_ADD: begin
            cmd.acc_add   = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_sel_y = 1'b1;
          end
          MS_Y_HI: begin
            cmd.wr_cr      = 1'b1;
            cmd.acc_load   = 1'b1;
            cmd.mul_en     = 1'b1;
            cmd.mul_sel_y  = 1'b1;
            cmd.mul_sel_hi = 1'b1;
          end
          MS_Y_ADD: begin
            cmd.acc_add = 1'b1;
          end
          MS_Y_WR: begin
            cmd.wr_ci = 1'b1;
          end
          default: begin
            cmd = '0;
          end
        endcase
      end
      ST_MUL: begin
        cmd.sq_en = 1'b1;
      end
      ST_UPD: begin
        cmd.z_upd  = !finish;
        cmd.out_wr = finish && out_free;
      end
    endcase
  end

  always_comb begin
    step_nxt = (state_r == ST_MAP && step_r != MS_Y_WR) ? map_step_t'(step_r + 3'd1)
                                                         : MS_X_LO;
    if (cmd.out_wr) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= MS_X_LO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[src/tce_dp.sv]
// ----------------------------------------------------------------------------
// tce_dp
// Datapath: pixel-to-point mapping with a shared 32x20 multiplier,
// squares of z, saturating update, escape test and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_dp
  import tce_pkg::*;
(
  input  wire                    clk,
  input  tce_cmd_t               cmd,
  output tce_sts_t               sts,
  input  wire [COORD_BITS-1:0]   pixel_x,
  input  wire [COORD_BITS-1:0]   pixel_y,
  input  wire [OFF_W-1:0]        offset_x,
  input  wire [OFF_W-1:0]        offset_y,
  input  wire [INV_W-1:0]        inv_scale,
  input  wire [CNT_W-1:0]        max_iter,
  output logic [COORD_BITS-1:0]  out_x,
  output logic [COORD_BITS-1:0]  out_y,
  output logic [CNT_W-1:0]       iteration_count,
  output logic                   inside_res
);

  // captured pixel and mapped differences
  logic [COORD_BITS-1:0]   px_r, py_r;
  logic [DMAG_W-1:0]       dmag_x_r, dmag_y_r;
  logic                    neg_x_r, neg_y_r;
  logic signed [D_W-1:0]   dx, dy;
  logic [D_W-1:0]          dx_mag, dy_mag;

  // mapping multiply-accumulate
  logic [DMAG_W-1:0]       mul_a;
  logic [INV_LO_W-1:0]     mul_b;
  logic [MPROD_W-1:0]      mprod_r;
  logic [ACC_W-1:0]        acc_r;

  // iteration state
  logic signed [WBITS-1:0] cr_r, ci_r, zr_r, zi_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [WBITS-1:0]        zr_mag, zi_mag;
  logic [PROD_W-1:0]       prr_r, pii_r, pri_r;
  logic                    pri_neg_r;

  logic [SQ_W-1:0]         sq_rr, sq_ii;
  logic [TW_W-1:0]         tw_mag;
  logic signed [ZW-1:0]    tw_s, zr_sum, zi_sum;
  logic [SQ_W:0]           esc_sum;
  logic                    big;

  // --- pixel capture
  assign dx = $signed({{(D_W-COORD_BITS-PIX_SH){1'b0}}, pixel_x, {PIX_SH{1'b0}}})
            - $signed({{(D_W-OFF_W){offset_x[OFF_W-1]}}, offset_x});
  assign dy = $signed({{(D_W-COORD_BITS-PIX_SH){1'b0}}, pixel_y, {PIX_SH{1'b0}}})
            - $signed({{(D_W-OFF_W){offset_y[OFF_W-1]}}, offset_y});
  assign dx_mag = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
  assign dy_mag = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r     <= pixel_x;
      py_r     <= pixel_y;
      dmag_x_r <= dx_mag[DMAG_W-1:0];
      dmag_y_r <= dy_mag[DMAG_W-1:0];
      neg_x_r  <= dx[D_W-1];
      neg_y_r  <= dy[D_W-1];
    end
  end

  // --- mapping: two partial products per coordinate
  assign mul_a = cmd.mul_sel_y ? dmag_y_r : dmag_x_r;
  assign mul_b = cmd.mul_sel_hi ? inv_scale[INV_W-1:INV_LO_W] : inv_scale[INV_LO_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      mprod_r <= mul_a * mul_b;
    end
    if (cmd.acc_load) begin
      acc_r <= {{(ACC_W-MPROD_W){1'b0}}, mprod_r};
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + {mprod_r, {INV_LO_W{1'b0}}};
    end
    if (cmd.wr_cr) begin
      cr_r <= map_sat(acc_r[ACC_W-1:MAP_SH], neg_x_r);
    end
    if (cmd.wr_ci) begin
      ci_r <= map_sat(acc_r[ACC_W-1:MAP_SH], neg_y_r);
    end
  end

  // --- squares of the current z
  assign zr_mag = zr_r[WBITS-1] ? -zr_r : zr_r;
  assign zi_mag = zi_r[WBITS-1] ? -zi_r : zi_r;

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      prr_r     <= zr_mag[MAG_W-1:0] * zr_mag[MAG_W-1:0];
      pii_r     <= zi_mag[MAG_W-1:0] * zi_mag[MAG_W-1:0];
      pri_r     <= zr_mag[MAG_W-1:0] * zi_mag[MAG_W-1:0];
      pri_neg_r <= zr_r[WBITS-1] ^ zi_r[WBITS-1];
    end
  end

  // --- escape test and update; products are exact whenever |z| < 2
  assign sq_rr  = prr_r[PROD_W-1:FRAC_BITS];
  assign sq_ii  = pii_r[PROD_W-1:FRAC_BITS];
  assign tw_mag = pri_r[PROD_W-1:FRAC_BITS-1];

  assign big     = (|zr_mag[WBITS-1:MAG_W]) || (|zi_mag[WBITS-1:MAG_W]);
  assign esc_sum = {1'b0, sq_rr} + {1'b0, sq_ii};
  assign sts.esc    = big || esc_sum[SQ_W];
  assign sts.at_max = (cnt_r == max_iter);

  assign tw_s   = pri_neg_r ? -$signed({{(ZW-TW_W){1'b0}}, tw_mag})
                            :  $signed({{(ZW-TW_W){1'b0}}, tw_mag});
  assign zr_sum = $signed({{(ZW-SQ_W){1'b0}}, sq_rr})
                - $signed({{(ZW-SQ_W){1'b0}}, sq_ii})
                - $signed({{(ZW-WBITS){cr_r[WBITS-1]}}, cr_r});
  assign zi_sum = $signed({{(ZW-WBITS){ci_r[WBITS-1]}}, ci_r}) - tw_s;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zr_r  <= '0;
      zi_r  <= '0;
      cnt_r <= '0;
    end else if (cmd.z_upd) begin
      zr_r  <= sat_word(zr_sum);
      zi_r  <= sat_word(zi_sum);
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // --- result register
  always_ff @(posedge clk) begin
    if (cmd.out_wr) begin
      out_x           <= px_r;
      out_y           <= py_r;
      iteration_count <= cnt_r;
      inside_res      <= sts.at_max;
    end
  end

endmodule

`default_nettype wire
